### rtl/core/falling_sand_grain_step_core_defines.svh
// Assertion macros shared by the falling sand grain step core.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef FALLING_SAND_GRAIN_STEP_CORE_DEFINES_SVH
`define FALLING_SAND_GRAIN_STEP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fsgs_pkg.sv
package fsgs_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] x;
    logic [6:0] y;
    logic       coin;
  } in_item_t;

  typedef struct packed {
    logic [7:0] new_x;
    logic [6:0] new_y;
    logic [2:0] status;
  } out_item_t;

  // Which cell the shared probe unit looks at, relative to the addressed cell.
  typedef enum logic [1:0] {
    PK_SELF,
    PK_BELOW,
    PK_LEFT,
    PK_RIGHT
  } probe_kind_t;

  // Coordinates and in-grid flag produced by the probe unit.
  typedef struct packed {
    logic [8:0] col;
    logic [7:0] row;
    logic       ok;
  } probe_pos_t;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [2:0] ST_PLACED     = 3'd0;
  localparam logic [2:0] ST_DOWN       = 3'd1;
  localparam logic [2:0] ST_DOWN_LEFT  = 3'd2;
  localparam logic [2:0] ST_DOWN_RIGHT = 3'd3;
  localparam logic [2:0] ST_STAYED     = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
  localparam logic [2:0] ST_REJECTED   = 3'd6;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [8:0] COLS_RESET = 9'd160;
  localparam logic [7:0] ROWS_RESET = 8'd120;

endpackage

### rtl/core/fsgs_probe.sv
// Shared neighbor probe: forms one neighbor coordinate, checks it against
// the active region and computes its occupancy memory address.
module fsgs_probe #(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_HEIGHT = 128
) (
  input  logic [7:0]                                      x,
  input  logic [6:0]                                      y,
  input  fsgs_pkg::probe_kind_t                           kind,
  input  logic [8:0]                                      eff_cols,
  input  logic [7:0]                                      eff_rows,
  output fsgs_pkg::probe_pos_t                            pos,
  output logic [$clog2(GRID_WIDTH * GRID_HEIGHT) - 1 : 0] addr
);

  localparam int unsigned AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  logic [8:0] col;
  logic [7:0] row;
  logic       col_ok;

  always_comb begin
    col    = {1'b0, x};
    row    = {1'b0, y};
    col_ok = 1'b1;
    unique case (kind)
      fsgs_pkg::PK_SELF: begin
      end
      fsgs_pkg::PK_BELOW: begin
        row = {1'b0, y} + 8'd1;
      end
      fsgs_pkg::PK_LEFT: begin
        row    = {1'b0, y} + 8'd1;
        col    = {1'b0, x} - 9'd1;
        col_ok = (x != 8'd0);
      end
      fsgs_pkg::PK_RIGHT: begin
        row = {1'b0, y} + 8'd1;
        col = {1'b0, x} + 9'd1;
      end
      default: begin
      end
    endcase
  end

  assign pos.col = col;
  assign pos.row = row;
  assign pos.ok  = col_ok && (col < eff_cols) && (row < eff_rows);

  // Row-major address; the product is by a constant, so it is a shift for
  // power-of-two widths. Only used when pos.ok is set.
  assign addr = AW'(AW'(row) * AW'(GRID_WIDTH) + AW'(col));

endmodule

### rtl/core/falling_sand_grain_step_core.sv
// Falling sand grain step core.
// Holds a one-bit occupancy grid of GRID_WIDTH x GRID_HEIGHT cells. Each transfer on
// the in_ channel carries one command: place a grain at (x, y), or step the grain at
// (x, y) by the falling sand rule (down, else down-left or down-right, else stay).
// Exactly one result transfer on the out_ channel follows each command, carrying
// the grain's new position and a status code.
// Commands are handled one at a time by a small sequencer around a single
// probe unit and an occupancy memory with one write port and a registered read port.
// A rejected or place command goes from the check state straight to the finish state,
// which loads the result register. A step reads the cell, then the cell below and, if that
// is taken, the diagonal cells in turn; a move then clears the source cell and sets the
// destination in two write states. in_ready is high again in the cycle after that load.
// The result sits in an output register; a stalled receiver holds it there, and
// the core takes the next command meanwhile, waiting only before it would
// overwrite a result that has not been taken.
// After reset the core sweeps all GRID_WIDTH * GRID_HEIGHT cells (32768 by default)
// to empty, one cell a cycle; in_ready stays low then.
// Configuration writes on the cfg_ port are taken at any time, including the sweep,
// but should only be issued while no command is outstanding.
module falling_sand_grain_step_core #(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_HEIGHT = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fsgs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata
);

  localparam int unsigned DEPTH   = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned COL_CAP = (GRID_WIDTH > 511) ? 511 : GRID_WIDTH;
  localparam int unsigned ROW_CAP = (GRID_HEIGHT > 255) ? 255 : GRID_HEIGHT;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD_SELF,
    S_RD_BELOW,
    S_RD_LEFT,
    S_RD_RIGHT,
    S_WR_CLEAR,
    S_WR_SET,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [8:0]            cols_r, cols_nxt;
  logic [7:0]            rows_r, rows_nxt;
  fsgs_pkg::in_item_t    item_r, item_nxt;
  fsgs_pkg::probe_kind_t move_kind_r, move_kind_nxt;
  logic                  left_ok_r, left_ok_nxt;
  logic                  right_ok_r, right_ok_nxt;
  logic                  left_free_r, left_free_nxt;
  fsgs_pkg::out_item_t   res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fsgs_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [8:0]            eff_cols;
  logic [7:0]            eff_rows;
  fsgs_pkg::probe_kind_t kind;
  fsgs_pkg::probe_pos_t  pos;
  logic [AW-1:0]         paddr;
  logic                  right_free;
  logic                  down_out;
  logic                  mem_set;

  // Occupancy memory: one write port and one registered read port.
  logic                  mem [DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic                  mem_wd;
  logic                  rd_en;
  logic                  rd_data_r;

  // Register values above the grid size saturate to it.
  assign eff_cols = (cols_r > 9'(COL_CAP)) ? 9'(COL_CAP) : cols_r;
  assign eff_rows = (rows_r > 8'(ROW_CAP)) ? 8'(ROW_CAP) : rows_r;

  fsgs_probe #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_probe (
    .x        (item_r.x),
    .y        (item_r.y),
    .kind     (kind),
    .eff_cols (eff_cols),
    .eff_rows (eff_rows),
    .pos      (pos),
    .addr     (paddr)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign right_free = right_ok_r && !rd_data_r;

  // Configuration register writes.
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fsgs_pkg::CFG_COLS: cols_nxt = cfg_wdata;
        fsgs_pkg::CFG_ROWS: rows_nxt = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: one probe and at most one memory access per cycle.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    item_nxt      = item_r;
    move_kind_nxt = move_kind_r;
    left_ok_nxt   = left_ok_r;
    right_ok_nxt  = right_ok_r;
    left_free_nxt = left_free_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind          = fsgs_pkg::PK_SELF;
    mem_we        = 1'b0;
    mem_wa        = paddr;
    mem_wd        = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        kind          = fsgs_pkg::PK_SELF;
        res_nxt.new_x = item_r.x;
        res_nxt.new_y = item_r.y;
        if (!pos.ok) begin
          res_nxt.status = fsgs_pkg::ST_REJECTED;
          state_nxt      = S_FINISH;
        end else if (item_r.opcode == fsgs_pkg::OP_PLACE) begin
          mem_we         = 1'b1;
          mem_wd         = 1'b1;
          res_nxt.status = fsgs_pkg::ST_PLACED;
          state_nxt      = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_RD_SELF;
        end
      end
      S_RD_SELF: begin
        // The cell below lies outside the grid exactly on the last row in use.
        kind = fsgs_pkg::PK_BELOW;
        if (!rd_data_r) begin
          res_nxt.status = fsgs_pkg::ST_EMPTY;
          state_nxt      = S_FINISH;
        end else if (!pos.ok) begin
          res_nxt.status = fsgs_pkg::ST_STAYED;
          state_nxt      = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_RD_BELOW;
        end
      end
      S_RD_BELOW: begin
        kind = fsgs_pkg::PK_LEFT;
        if (!rd_data_r) begin
          move_kind_nxt  = fsgs_pkg::PK_BELOW;
          res_nxt.status = fsgs_pkg::ST_DOWN;
          state_nxt      = S_WR_CLEAR;
        end else begin
          left_ok_nxt = pos.ok;
          rd_en       = pos.ok;
          state_nxt   = S_RD_LEFT;
        end
      end
      S_RD_LEFT: begin
        kind          = fsgs_pkg::PK_RIGHT;
        left_free_nxt = left_ok_r && !rd_data_r;
        right_ok_nxt  = pos.ok;
        rd_en         = pos.ok;
        state_nxt     = S_RD_RIGHT;
      end
      S_RD_RIGHT: begin
        if (left_free_r && (!right_free || !item_r.coin)) begin
          move_kind_nxt  = fsgs_pkg::PK_LEFT;
          res_nxt.status = fsgs_pkg::ST_DOWN_LEFT;
          state_nxt      = S_WR_CLEAR;
        end else if (right_free) begin
          move_kind_nxt  = fsgs_pkg::PK_RIGHT;
          res_nxt.status = fsgs_pkg::ST_DOWN_RIGHT;
          state_nxt      = S_WR_CLEAR;
        end else begin
          res_nxt.status = fsgs_pkg::ST_STAYED;
          state_nxt      = S_FINISH;
        end
      end
      S_WR_CLEAR: begin
        kind      = fsgs_pkg::PK_SELF;
        mem_we    = 1'b1;
        state_nxt = S_WR_SET;
      end
      S_WR_SET: begin
        kind          = move_kind_r;
        mem_we        = 1'b1;
        mem_wd        = 1'b1;
        res_nxt.new_x = pos.col[7:0];
        res_nxt.new_y = pos.row[6:0];
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        // Wait only if an earlier result is still held and not being taken.
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cols_r      <= fsgs_pkg::COLS_RESET;
      rows_r      <= fsgs_pkg::ROWS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      move_kind_r <= move_kind_nxt;
      left_ok_r   <= left_ok_nxt;
      right_ok_r  <= right_ok_nxt;
      left_free_r <= left_free_nxt;
      res_r       <= res_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[paddr];
    end
  end

  assign down_out = out_valid && (out_data.status == fsgs_pkg::ST_DOWN);
  assign mem_set  = mem_we && mem_wd;

`include "falling_sand_grain_step_core_defines.svh"

  // One command at a time: a transfer in closes the input until the result is staged.
  `FSGS_ASSERT_NEXT(a_single_cmd, in_valid && in_ready, !in_ready, "input open after transfer")
  // A downward move always lands below the top row.
  `FSGS_ASSERT_SAME(a_down_row, down_out, out_data.new_y != 7'd0, "down move on top row")
  // The destination cell is set only right after the source cell was cleared.
  `FSGS_ASSERT_SAME(a_move_order, state_r == S_WR_SET, $past(state_r) == S_WR_CLEAR, "no clear")
  // Cells are marked occupied only by a place command or the second move write.
  `FSGS_ASSERT_SAME(a_set_source, mem_set, state_r == S_CHECK || state_r == S_WR_SET, "stray set")

endmodule
